// ===== design/uart_trx_pkg.sv =====
`default_nettype none

package uart_trx_pkg;

  // Widths fixed by the register map
  localparam int PERIOD_W    = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int BYTE_W      = 8;

  // Packed item widths on the stream ports
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_LOGIC = 1'd1;

  // Transmitter view of one tick
  typedef struct packed {
    logic level;
    logic busy;
  } tx_result_t;

  // Receiver view of one tick
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              busy;
  } rx_result_t;

endpackage

`default_nettype wire

// ===== design/uart_trx_tx.sv =====
`default_nettype none

module uart_trx_tx
  import uart_trx_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [PERIOD_W-1:0] bit_period,
  input  wire logic                invert_logic,
  input  wire logic                send_request,
  input  wire logic [BYTE_W-1:0]   send_byte,
  output tx_result_t               result
);

  // room for the slot index one past the stop slot
  localparam int IDX_W = $clog2(DATA_BITS + 3);
  localparam int SEL_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam logic [IDX_W-1:0] STOP_IDX = IDX_W'(DATA_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_DATA_IDX = IDX_W'(DATA_BITS);

  logic [DATA_BITS-1:0] tx_shift, tx_shift_next;
  logic [IDX_W-1:0]     tx_bit_index, tx_bit_index_next;
  logic [PERIOD_W-1:0]  tx_tick_count, tx_tick_count_next;
  logic                 tx_active, tx_active_next;

  logic                   enabled;
  logic                   start;
  logic                   active_cur;
  logic [IDX_W-1:0]       idx_cur;
  logic [IDX_W-1:0]       idx_m1;
  logic [IDX_W-1:0]       idx_inc;
  logic [PERIOD_W:0]      cnt_inc;
  logic [DATA_BITS+7:0]   byte_wide;
  logic                   slot_bit;

  assign enabled   = (bit_period != '0);
  assign byte_wide = {{DATA_BITS{1'b0}}, send_byte};

  // Work out the slot level and the next frame state for this tick
  always_comb begin
    active_cur = tx_active && enabled;
    start      = !active_cur && send_request && enabled;
    idx_cur    = (enabled && !start) ? tx_bit_index : '0;
    tx_shift_next      = start ? byte_wide[DATA_BITS-1:0] : tx_shift;
    tx_active_next     = active_cur || start;
    tx_bit_index_next  = idx_cur;
    tx_tick_count_next = (enabled && !start) ? tx_tick_count : '0;
    idx_m1   = idx_cur - 1'b1;
    idx_inc  = idx_cur + 1'b1;
    cnt_inc  = {1'b0, tx_tick_count_next} + 1'b1;

    // start bit low, data LSB first, stop bit high
    if (idx_cur == '0) begin
      slot_bit = 1'b0;
    end else if (idx_cur <= LAST_DATA_IDX) begin
      slot_bit = tx_shift_next[idx_m1[SEL_W-1:0]];
    end else begin
      slot_bit = 1'b1;
    end

    if (tx_active_next) begin
      result.level = slot_bit ^ invert_logic;
      result.busy  = 1'b1;
      if (cnt_inc >= {1'b0, bit_period}) begin
        tx_tick_count_next = '0;
        if (idx_inc > STOP_IDX) begin
          tx_bit_index_next = '0;
          tx_active_next    = 1'b0;
        end else begin
          tx_bit_index_next = idx_inc;
        end
      end else begin
        tx_tick_count_next = cnt_inc[PERIOD_W-1:0];
      end
    end else begin
      result.level = ~invert_logic;
      result.busy  = 1'b0;
    end
  end

  // Advance the frame state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_active     <= 1'b0;
      tx_bit_index  <= '0;
      tx_tick_count <= '0;
    end else if (step) begin
      tx_active     <= tx_active_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_tick_count <= tx_tick_count_next;
    end
  end

  // Hold the frame data
  always_ff @(posedge clk) begin
    if (step) begin
      tx_shift <= tx_shift_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/uart_trx_rx.sv =====
`default_nettype none

module uart_trx_rx
  import uart_trx_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [PERIOD_W-1:0] bit_period,
  input  wire logic                invert_logic,
  input  wire logic                rx_level,
  output rx_result_t               result
);

  localparam int IDX_W = $clog2(DATA_BITS + 1);
  localparam int CNT_W = PERIOD_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RECV,
    PH_GUARD
  } rx_phase_t;

  rx_phase_t            rx_phase, rx_phase_next;
  logic [IDX_W-1:0]     rx_bit_index, rx_bit_index_next;
  logic [CNT_W-1:0]     rx_tick_count, rx_tick_count_next;
  logic [DATA_BITS-1:0] rx_shift, rx_shift_next;

  logic                 enabled;
  rx_phase_t            phase_cur;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W-1:0]     period_ext;
  logic [CNT_W-1:0]     first_wait;
  logic [CNT_W-1:0]     guard_wait;
  logic [IDX_W-1:0]     idx_inc;
  logic [DATA_BITS+7:0] shift_wide;

  assign enabled    = (bit_period != '0);
  assign period_ext = {2'b00, bit_period};
  assign first_wait = {3'b000, bit_period[PERIOD_W-1:1]} + period_ext;
  assign guard_wait = {1'b0, bit_period, 1'b0} + period_ext;

  // Step the receive sequencer for this tick
  always_comb begin
    phase_cur          = enabled ? rx_phase : PH_IDLE;
    rx_phase_next      = phase_cur;
    rx_bit_index_next  = enabled ? rx_bit_index : '0;
    rx_tick_count_next = enabled ? rx_tick_count : '0;
    rx_shift_next      = rx_shift;
    cnt_dec            = (rx_tick_count_next != '0) ? rx_tick_count_next - 1'b1
                                                    : rx_tick_count_next;
    idx_inc            = rx_bit_index_next + 1'b1;
    result.valid       = 1'b0;

    unique case (phase_cur)
      PH_RECV: begin
        rx_tick_count_next = cnt_dec;
        if (cnt_dec == '0) begin
          // sample mid-bit, shift in from the top
          rx_shift_next = {rx_level ^ invert_logic, rx_shift[DATA_BITS-1:1]};
          if (idx_inc >= LAST_IDX) begin
            result.valid       = 1'b1;
            rx_bit_index_next  = '0;
            rx_phase_next      = PH_GUARD;
            rx_tick_count_next = guard_wait;
          end else begin
            rx_bit_index_next  = idx_inc;
            rx_tick_count_next = period_ext;
          end
        end
      end
      PH_GUARD: begin
        rx_tick_count_next = cnt_dec;
        if (cnt_dec == '0) begin
          rx_phase_next = PH_IDLE;
        end
      end
      default: begin
        rx_phase_next = PH_IDLE;
        if (enabled && (rx_level == invert_logic)) begin
          rx_phase_next      = PH_RECV;
          rx_bit_index_next  = '0;
          rx_shift_next      = '0;
          rx_tick_count_next = first_wait;
        end
      end
    endcase

    shift_wide  = {8'h00, rx_shift_next};
    result.data = result.valid ? shift_wide[BYTE_W-1:0] : '0;
    result.busy = (rx_phase_next != PH_IDLE);
  end

  // Advance the sequencer on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= PH_IDLE;
      rx_bit_index  <= '0;
      rx_tick_count <= '0;
    end else if (step) begin
      rx_phase      <= rx_phase_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_tick_count <= rx_tick_count_next;
    end
  end

  // Hold the assembled bits
  always_ff @(posedge clk) begin
    if (step) begin
      rx_shift <= rx_shift_next;
    end
  end

  a_guard_idx_clear: assert property (@(posedge clk) disable iff (rst)
    rx_phase == PH_GUARD |-> rx_bit_index == '0)
    else $error("rx guard time with a nonzero bit index");

  a_recv_idx_range: assert property (@(posedge clk) disable iff (rst)
    rx_phase == PH_RECV |-> rx_bit_index < LAST_IDX)
    else $error("rx bit index past the data width while receiving");

  a_busy_count_live: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == PH_RECV || rx_phase == PH_GUARD) |-> rx_tick_count != '0)
    else $error("rx countdown at zero while busy");

endmodule

`default_nettype wire

// ===== design/uart_transceiver_8n1.sv =====
// Each accepted item's result is registered in the output register at the accepting edge.
// Throughput: one item per cycle unless the output register is stalled; each item is one tick
//   of line sampling; its TX and RX state is updated in one pass between state and output regs.
// Reset (rst, synchronous): bit period 0 (block disabled), normal polarity, TX and RX
//   idle, output register empty.
`default_nettype none

module uart_transceiver_8n1
  import uart_trx_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  input  wire logic [S_DATA_W-1:0]    s_tdata,   // rx_level, send_request, send_byte[7:0]
  // result items
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  output      logic [M_DATA_W-1:0]    m_tdata    // tx_level, tx_busy, rx_valid, rx_byte, rx_busy
);

  logic [PERIOD_W-1:0] bit_period;
  logic                invert_logic;
  logic                accept;
  tx_result_t          tx_res;
  rx_result_t          rx_res;
  logic [M_DATA_W-1:0] result_packed;

  // Take a new item whenever the output register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period   <= '0;
      invert_logic <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_PERIOD:   bit_period   <= cfg_data[PERIOD_W-1:0];
        CFG_INVERT_LOGIC: invert_logic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  uart_trx_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .bit_period   (bit_period),
    .invert_logic (invert_logic),
    .send_request (s_tdata[1]),
    .send_byte    (s_tdata[9:2]),
    .result       (tx_res)
  );

  uart_trx_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .bit_period   (bit_period),
    .invert_logic (invert_logic),
    .rx_level     (s_tdata[0]),
    .result       (rx_res)
  );

  // Pack the result item, lowest field first
  assign result_packed = {4'h0, rx_res.busy, rx_res.data, rx_res.valid,
                          tx_res.busy, tx_res.level};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_packed;
    end
  end

  a_valid_implies_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[11])
    else $error("received byte reported without rx busy");

  a_disabled_idle: assert property (@(posedge clk) disable iff (rst)
    accept && bit_period == '0 |=> !m_tdata[1] && !m_tdata[11] && !m_tdata[2])
    else $error("activity reported while disabled");

  a_idle_line_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[0] == !invert_logic)
    else $error("tx line not at idle level while not busy");

endmodule

`default_nettype wire

// ===== tb/sv/tb_uart_transceiver_8n1.sv =====
`timescale 1ns / 100ps

module tb_uart_transceiver_8n1;
  import uart_trx_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  // One tick of line input, packed as on s_tdata (rx_level in bit 0)
  typedef struct packed {
    logic [BYTE_W-1:0] send_byte;
    logic              send_request;
    logic              rx_level;
  } line_item_t;

  typedef struct packed {
    tx_result_t tx;
    rx_result_t rx;
  } tick_result_t;

  typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_GUARD} rx_mode_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_BIT_PERIOD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata = '0;   // rx_level, send_request, send_byte[7:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;        // tx_level, tx_busy, rx_valid, rx_byte, rx_busy

  // Line state tracked alongside the block
  logic [15:0]       cur_period;
  logic              cur_invert;
  logic [BYTE_W-1:0] tx_frame;
  logic [3:0]        tx_slot;
  logic [15:0]       tx_ticks;
  logic              tx_on;
  rx_mode_t          rx_mode;
  logic [3:0]        rx_bits;
  logic [17:0]       rx_wait;
  logic [BYTE_W-1:0] rx_accum;

  tick_result_t pending_levels[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  uart_transceiver_8n1 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the tracked TX and RX state by one tick
  function automatic tick_result_t step_line_state(input line_item_t it);
    tick_result_t r;
    logic         bitv;
    r = '0;
    if (cur_period == 16'd0) begin
      tx_on    = 1'b0;
      tx_slot  = '0;
      tx_ticks = '0;
      rx_mode  = RX_IDLE;
      rx_bits  = '0;
      rx_wait  = '0;
    end

    // Transmitter: start bit goes out on the tick that takes the request
    if (!tx_on && it.send_request && cur_period != 16'd0) begin
      tx_frame = it.send_byte;
      tx_on    = 1'b1;
      tx_slot  = '0;
      tx_ticks = '0;
    end
    if (tx_on) begin
      if (tx_slot == 4'd0) bitv = 1'b0;
      else if (tx_slot <= BYTE_W) bitv = tx_frame[tx_slot - 4'd1];
      else bitv = 1'b1;
      r.tx.level = bitv ^ cur_invert;
      r.tx.busy  = 1'b1;
      tx_ticks   = tx_ticks + 16'd1;
      if (tx_ticks >= cur_period) begin
        tx_ticks = '0;
        tx_slot  = tx_slot + 4'd1;
        if (tx_slot > BYTE_W + 1) begin
          tx_slot = '0;
          tx_on   = 1'b0;
        end
      end
    end else begin
      r.tx.level = ~cur_invert;
      r.tx.busy  = 1'b0;
    end

    // Receiver: mid-bit sampling, then guard time of three bit periods
    case (rx_mode)
      RX_DATA: begin
        if (rx_wait > 0) rx_wait = rx_wait - 18'd1;
        if (rx_wait == 0) begin
          rx_accum = {it.rx_level ^ cur_invert, rx_accum[BYTE_W-1:1]};
          rx_bits  = rx_bits + 4'd1;
          if (rx_bits >= BYTE_W) begin
            r.rx.valid = 1'b1;
            r.rx.data  = rx_accum;
            rx_bits    = '0;
            rx_mode    = RX_GUARD;
            rx_wait    = 18'(3 * cur_period);
          end else begin
            rx_wait = 18'(cur_period);
          end
        end
      end
      RX_GUARD: begin
        if (rx_wait > 0) rx_wait = rx_wait - 18'd1;
        if (rx_wait == 0) rx_mode = RX_IDLE;
      end
      default: begin
        rx_mode = RX_IDLE;
        if (cur_period != 16'd0 && it.rx_level == cur_invert) begin
          rx_mode  = RX_DATA;
          rx_bits  = '0;
          rx_accum = '0;
          rx_wait  = 18'(cur_period) + 18'(cur_period >> 1);
        end
      end
    endcase
    r.rx.busy = (rx_mode != RX_IDLE);
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    if (mismatches < 10) $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  // Track config writes, predict each accepted item, check each result
  always @(posedge clk) begin : predict_and_check
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      cur_period = '0;
      cur_invert = 1'b0;
      tx_frame   = '0;
      tx_slot    = '0;
      tx_ticks   = '0;
      tx_on      = 1'b0;
      rx_mode    = RX_IDLE;
      rx_bits    = '0;
      rx_wait    = '0;
      rx_accum   = '0;
      pending_levels.delete();
    end else begin
      // an item taken on the same edge as a write still sees the old setting
      if (s_tvalid && s_tready)
        pending_levels.push_back(step_line_state(line_item_t'(s_tdata[BYTE_W+1:0])));
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIT_PERIOD:   cur_period = cfg_data[15:0];
          CFG_INVERT_LOGIC: cur_invert = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.tx.level = m_tdata[0];
        got.tx.busy  = m_tdata[1];
        got.rx.valid = m_tdata[2];
        got.rx.data  = m_tdata[10:3];
        got.rx.busy  = m_tdata[11];
        if (pending_levels.size() == 0) begin
          note_failure("result with nothing expected");
        end else begin
          want = pending_levels.pop_front();
          check_field("tx_level", want.tx.level, got.tx.level);
          check_field("tx_busy", want.tx.busy, got.tx.busy);
          check_field("rx_valid", want.rx.valid, got.rx.valid);
          check_field("rx_byte", want.rx.data, got.rx.data);
          check_field("rx_busy", want.rx.busy, got.rx.busy);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = gaps_on ? pick_gap() : 0;
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Stop the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("uart_transceiver_8n1 regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item, after an optional gap, and hold it until taken
  task automatic send_tick(input line_item_t it);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(it);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drive a line level with a random send request riding along
  task automatic send_line(input logic level);
    line_item_t it;
    it.rx_level     = level;
    it.send_request = ($urandom_range(0, 5) == 0);
    it.send_byte    = 8'($urandom_range(0, 255));
    send_tick(it);
  endtask

  // Wait until every expected result is in
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input int period, input logic invert);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BIT_PERIOD;
    cfg_data  <= CFG_DATA_W'(period);
    @(posedge clk);
    cfg_index <= CFG_INVERT_LOGIC;
    cfg_data  <= CFG_DATA_W'(invert);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Send a serial frame on the RX line; a broken one is cut short and
  // then held at the start level
  task automatic send_uart_frame(input logic [7:0] data, input int period,
                                 input logic invert, input bit broken);
    int   slots;
    logic level;
    slots = broken ? $urandom_range(1, 9) : 10;
    for (int s = 0; s < slots; s++) begin
      if (s == 0) level = 1'b0;
      else if (s <= BYTE_W) level = data[s-1];
      else level = 1'b1;
      repeat (period) send_line(level ^ invert);
    end
    if (broken) repeat (period) send_line(invert);
  endtask

  // Mostly well-formed frames, some broken ones and noise, idle in between
  task automatic run_traffic(input int period, input logic invert, input int count);
    int   first;
    int   r;
    bit   framed;
    first  = items_sent;
    framed = (period > 0 && period <= 64);
    while (items_sent - first < count) begin
      r = $urandom_range(0, 99);
      if (framed && r < 75) begin
        send_uart_frame(8'($urandom_range(0, 255)), period, invert, 1'b0);
      end else if (framed && r < 87) begin
        send_uart_frame(8'($urandom_range(0, 255)), period, invert, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_line(1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, framed ? 2 * period : 4)) send_line(~invert);
    end
  endtask

  task automatic test_disabled();
    write_config(0, 1'b0);
    send_tick('{send_byte: 8'hFF, send_request: 1'b1, rx_level: 1'b0});
    send_tick('{send_byte: 8'h00, send_request: 1'b1, rx_level: 1'b1});
    send_tick('{send_byte: 8'h5A, send_request: 1'b0, rx_level: 1'b0});
    drain_results();
  endtask

  // Period 1: request taken, request while busy ignored, RX frame of all
  // zeros, and a new start seen right at the end of the guard time
  task automatic test_frame_basics();
    write_config(1, 1'b0);
    send_tick('{send_byte: 8'hFF, send_request: 1'b1, rx_level: 1'b0});
    send_tick('{send_byte: 8'h00, send_request: 1'b1, rx_level: 1'b0});
    repeat (7) send_tick('{send_byte: 8'h00, send_request: 1'b0, rx_level: 1'b0});
    send_tick('{send_byte: 8'h00, send_request: 1'b0, rx_level: 1'b1});
    send_tick('{send_byte: 8'h00, send_request: 1'b1, rx_level: 1'b1});
    send_tick('{send_byte: 8'hFF, send_request: 1'b0, rx_level: 1'b1});
    send_tick('{send_byte: 8'hFF, send_request: 1'b0, rx_level: 1'b0});
    drain_results();
  endtask

  // Change period and polarity while both directions are mid-frame
  task automatic test_period_change();
    write_config(2, 1'b1);
    repeat (10) send_tick('{send_byte: 8'hFF, send_request: 1'b0,
                            rx_level: logic'($urandom_range(0, 1))});
    drain_results();
  endtask

  task automatic test_random_phases();
    int periods[8] = '{1, 2, 3, 5, 8, 65535, 0, 4};
    bit inverts[8] = '{0, 1, 0, 1, 1, 0, 1, 0};
    int counts[8]  = '{300, 250, 250, 250, 250, 60, 40, 200};
    for (int p = 0; p < 8; p++) begin
      gaps_on = (p % 2 == 0);
      write_config(periods[p], inverts[p]);
      run_traffic(periods[p], inverts[p], counts[p]);
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  // Hold off the result side long enough that the block stalls its input
  task automatic test_result_hold();
    write_config(3, 1'b0);
    gaps_on      = 1'b0;
    hold_request = 300;
    run_traffic(3, 1'b0, 200);
    drain_results();
    gaps_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled();
    test_frame_basics();
    test_period_change();
    test_random_phases();
    test_result_hold();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("uart_transceiver_8n1 regression: pass");
    end else begin
      $display("uart_transceiver_8n1 regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/uart_trx_pkg.sv
design/uart_trx_tx.sv
design/uart_trx_rx.sv
design/uart_transceiver_8n1.sv
tb/sv/tb_uart_transceiver_8n1.sv
